[rtl/gwe_pkg.sv]
// Shared constants and types for the grid wall edge extractor.
// No dependencies; every other file refers to this package by scoped names.
package gwe_pkg;

    // Largest supported grid dimension (default for the top-level parameter)
    localparam int MAX_TILES_DEF = 1024;

    // Field widths
    localparam int SIZE_W     = 10;  // tile_size
    localparam int COUNT_W    = 11;  // tiles_across / tiles_deep
    localparam int CFG_DATA_W = 11;  // widest register
    localparam int REG_IDX_W  = 2;
    localparam int OUT_IDX_W  = 10;  // wall_tile_col / wall_tile_row
    localparam int POS_W      = 22;  // doubled wall centre coordinates

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_TILE_SIZE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TILES_ACROSS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TILES_DEEP   = 2'd2;

    // Wall side codes
    typedef enum logic [1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_TOP    = 2'd2,
        SIDE_BOTTOM = 2'd3
    } side_t;

endpackage

[rtl/gwe_channels.sv]
// Valid/ready channel interfaces: tile input and wall result.
// Depends on gwe_pkg for field widths.
interface gwe_tile_if;
    logic valid;
    logic ready;
    logic tile_open;
    logic map_start;

    modport source (output valid, output tile_open, output map_start, input ready);
    modport sink   (input valid, input tile_open, input map_start, output ready);
endinterface

interface gwe_wall_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            wall_side;
    logic [gwe_pkg::OUT_IDX_W-1:0]         wall_tile_col;
    logic [gwe_pkg::OUT_IDX_W-1:0]         wall_tile_row;
    logic signed [gwe_pkg::POS_W-1:0]      wall_pos_x2;
    logic signed [gwe_pkg::POS_W-1:0]      wall_pos_z2;
    logic                                  run_last;

    modport source (output valid, output wall_side, output wall_tile_col,
                    output wall_tile_row, output wall_pos_x2, output wall_pos_z2,
                    output run_last, input ready);
    modport sink   (input valid, input wall_side, input wall_tile_col,
                    input wall_tile_row, input wall_pos_x2, input wall_pos_z2,
                    input run_last, output ready);
endinterface

[rtl/gwe_pos_calc.sv]
// Wall centre position calculator (combinational), doubled world units.
// Depends on gwe_pkg. All math is modulo 2^POS_W, matching the output width.
module gwe_pos_calc #(
    parameter int CNT_W = 10
) (
    input  gwe_pkg::side_t                      side,
    input  logic [CNT_W-1:0]                    col,
    input  logic [CNT_W-1:0]                    row,
    input  logic [gwe_pkg::SIZE_W-1:0]          tile_size,
    input  logic [gwe_pkg::POS_W-1:0]           w_span,
    input  logic [gwe_pkg::POS_W-1:0]           d_span,
    output logic signed [gwe_pkg::POS_W-1:0]    pos_x2,
    output logic signed [gwe_pkg::POS_W-1:0]    pos_z2
);

    logic [gwe_pkg::SIZE_W+CNT_W-1:0] sc;
    logic [gwe_pkg::SIZE_W+CNT_W-1:0] sr;
    logic [gwe_pkg::POS_W-1:0]        bx;
    logic [gwe_pkg::POS_W-1:0]        bz;
    logic [gwe_pkg::POS_W-1:0]        s2;
    logic [gwe_pkg::POS_W-1:0]        h2;
    logic [gwe_pkg::POS_W-1:0]        x_sum;
    logic [gwe_pkg::POS_W-1:0]        z_sum;

    assign sc = tile_size * col;
    assign sr = tile_size * row;
    assign bx = gwe_pkg::POS_W'({sc, 1'b0});
    assign bz = gwe_pkg::POS_W'({sr, 1'b0});
    assign s2 = gwe_pkg::POS_W'({tile_size, 1'b0});
    // 2*floor(s/2) is s with its low bit cleared
    assign h2 = gwe_pkg::POS_W'({tile_size[gwe_pkg::SIZE_W-1:1], 1'b0});

    always_comb
    begin
        case (side)
            gwe_pkg::SIDE_LEFT:
            begin
                x_sum = bx - w_span;
                z_sum = bz + h2 - d_span;
            end
            gwe_pkg::SIDE_RIGHT:
            begin
                x_sum = bx + s2 - w_span;
                z_sum = bz + h2 - d_span;
            end
            gwe_pkg::SIDE_TOP:
            begin
                x_sum = bx + h2 - w_span;
                z_sum = bz - d_span;
            end
            default:
            begin
                x_sum = bx + h2 - w_span;
                z_sum = bz + s2 - d_span;
            end
        endcase
    end

    assign pos_x2 = signed'(x_sum);
    assign pos_z2 = signed'(z_sum);

endmodule

[rtl/grid_wall_edge_extractor.sv]
// A transferred tile is held in the compare stage; its walls leave through the result register.
// Throughput: one tile per cycle while tiles cause at most one wall and that wall can be
// loaded; a tile with two walls holds the input until its second wall is loaded, as the
// single result register sends one wall per cycle while the receiver takes them.
// Reset: handshake state, counters and left flag clear; registers go to 1. The
// row flag memory is not cleared.
module grid_wall_edge_extractor #(
    parameter int MAX_TILES = gwe_pkg::MAX_TILES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gwe_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [gwe_pkg::CFG_DATA_W-1:0]   cfg_data,
    gwe_tile_if.sink                         tiles,
    gwe_wall_if.source                       walls
);

    localparam int CNT_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int CLW   = $clog2(MAX_TILES + 1);

    // Configuration registers
    logic [gwe_pkg::SIZE_W-1:0]  tile_size_reg;
    logic [gwe_pkg::COUNT_W-1:0] tiles_across_reg;
    logic [gwe_pkg::COUNT_W-1:0] tiles_deep_reg;

    logic [CLW-1:0]              across_cl;
    logic [CLW-1:0]              deep_cl;
    logic [gwe_pkg::POS_W-1:0]   w_span_reg;
    logic [gwe_pkg::POS_W-1:0]   d_span_reg;

    // Position tracking
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;
    logic             left_reg;
    logic [CNT_W-1:0] c_in;
    logic [CNT_W-1:0] r_in;

    logic row_mem [MAX_TILES];

    // Compare stage
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_a_done_reg;
    logic             s1_a_done_next;
    logic             s1_cur_reg;
    logic             s1_left_reg;
    logic             s1_above_reg;
    logic [CNT_W-1:0] s1_col_reg;
    logic [CNT_W-1:0] s1_row_reg;

    logic             need_a;
    logic             need_b;
    logic             pend_a;
    logic             out_load_ok;
    logic             out_load;
    logic             s1_done;
    logic             in_fire;
    logic             sel_last;
    gwe_pkg::side_t   sel_side;
    logic [CNT_W-1:0] own_col;
    logic [CNT_W-1:0] own_row;
    logic signed [gwe_pkg::POS_W-1:0] calc_x2;
    logic signed [gwe_pkg::POS_W-1:0] calc_z2;

    // Result register
    logic                                out_valid_reg;
    logic                                out_valid_next;
    gwe_pkg::side_t                      out_side_reg;
    logic [gwe_pkg::OUT_IDX_W-1:0]       out_col_reg;
    logic [gwe_pkg::OUT_IDX_W-1:0]       out_row_reg;
    logic signed [gwe_pkg::POS_W-1:0]    out_x2_reg;
    logic signed [gwe_pkg::POS_W-1:0]    out_z2_reg;
    logic                                out_last_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_size_reg    <= gwe_pkg::SIZE_W'(1);
            tiles_across_reg <= gwe_pkg::COUNT_W'(1);
            tiles_deep_reg   <= gwe_pkg::COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gwe_pkg::REG_TILE_SIZE:    tile_size_reg    <= cfg_data[gwe_pkg::SIZE_W-1:0];
                gwe_pkg::REG_TILES_ACROSS: tiles_across_reg <= cfg_data[gwe_pkg::COUNT_W-1:0];
                gwe_pkg::REG_TILES_DEEP:   tiles_deep_reg   <= cfg_data[gwe_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (tiles_across_reg == '0)
            across_cl = CLW'(1);
        else if (32'(tiles_across_reg) > MAX_TILES)
            across_cl = CLW'(MAX_TILES);
        else
            across_cl = CLW'(tiles_across_reg);

        if (tiles_deep_reg == '0)
            deep_cl = CLW'(1);
        else if (32'(tiles_deep_reg) > MAX_TILES)
            deep_cl = CLW'(MAX_TILES);
        else
            deep_cl = CLW'(tiles_deep_reg);
    end

    // Spans follow the registers in the next cycle; user keeps config quiet then, unenforced
    always_ff @(posedge clk)
    begin
        w_span_reg <= gwe_pkg::POS_W'(tile_size_reg) * gwe_pkg::POS_W'(across_cl);
        d_span_reg <= gwe_pkg::POS_W'(tile_size_reg) * gwe_pkg::POS_W'(deep_cl);
    end

    // ---------------- input side ----------------
    assign in_fire = tiles.valid && tiles.ready;
    assign c_in    = tiles.map_start ? '0 : col_reg;
    assign r_in    = tiles.map_start ? '0 : row_reg;

    always_comb
    begin
        if ((CLW+1)'(c_in) + 1'b1 >= (CLW+1)'(across_cl))
        begin
            col_next = '0;
            if ((CLW+1)'(r_in) + 1'b1 >= (CLW+1)'(deep_cl))
                row_next = '0;
            else
                row_next = r_in + 1'b1;
        end
        else
        begin
            col_next = c_in + 1'b1;
            row_next = r_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= tiles.tile_open;
        end
    end

    // Row flag memory: read old flag and write new one at the same column
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_above_reg   <= row_mem[c_in];
            row_mem[c_in]  <= tiles.tile_open;
            s1_cur_reg     <= tiles.tile_open;
            s1_left_reg    <= left_reg;
            s1_col_reg     <= c_in;
            s1_row_reg     <= r_in;
        end
    end

    // ---------------- compare stage ----------------
    assign need_a      = (s1_col_reg != '0) && (s1_cur_reg != s1_left_reg);
    assign need_b      = (s1_row_reg != '0) && (s1_cur_reg != s1_above_reg);
    assign pend_a      = need_a && !s1_a_done_reg;
    assign out_load_ok = !out_valid_reg || walls.ready;
    assign out_load    = s1_valid_reg && out_load_ok && (pend_a || need_b);
    assign s1_done     = s1_valid_reg &&
                         ((!pend_a && !need_b) || (out_load_ok && !(pend_a && need_b)));
    assign tiles.ready = !s1_valid_reg || s1_done;
    assign sel_last    = !(pend_a && need_b);

    always_comb
    begin
        own_col = s1_col_reg;
        own_row = s1_row_reg;
        if (pend_a)
            sel_side = s1_cur_reg ? gwe_pkg::SIDE_RIGHT : gwe_pkg::SIDE_LEFT;
        else
            sel_side = s1_cur_reg ? gwe_pkg::SIDE_BOTTOM : gwe_pkg::SIDE_TOP;
        case (sel_side)
            gwe_pkg::SIDE_RIGHT:  own_col = s1_col_reg - 1'b1;
            gwe_pkg::SIDE_BOTTOM: own_row = s1_row_reg - 1'b1;
            default: ;
        endcase
    end

    gwe_pos_calc #(
        .CNT_W (CNT_W)
    ) u_pos_calc (
        .side      (sel_side),
        .col       (own_col),
        .row       (own_row),
        .tile_size (tile_size_reg),
        .w_span    (w_span_reg),
        .d_span    (d_span_reg),
        .pos_x2    (calc_x2),
        .pos_z2    (calc_z2)
    );

    always_comb
    begin
        s1_valid_next  = in_fire ? 1'b1 : (s1_done ? 1'b0 : s1_valid_reg);
        // first of two walls loaded, item stays for the second
        s1_a_done_next = (in_fire || s1_done) ? 1'b0 : (out_load ? 1'b1 : s1_a_done_reg);
        out_valid_next = out_load ? 1'b1 : (walls.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_a_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_a_done_reg <= s1_a_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_side_reg <= sel_side;
            out_col_reg  <= gwe_pkg::OUT_IDX_W'(own_col);
            out_row_reg  <= gwe_pkg::OUT_IDX_W'(own_row);
            out_x2_reg   <= calc_x2;
            out_z2_reg   <= calc_z2;
            out_last_reg <= sel_last;
        end
    end

    assign walls.valid         = out_valid_reg;
    assign walls.wall_side     = out_side_reg;
    assign walls.wall_tile_col = out_col_reg;
    assign walls.wall_tile_row = out_row_reg;
    assign walls.wall_pos_x2   = out_x2_reg;
    assign walls.wall_pos_z2   = out_z2_reg;
    assign walls.run_last      = out_last_reg;

    // ---------------- assertions ----------------
    a_done_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        s1_a_done_reg |-> s1_valid_reg)
        else $error("second-wall flag set with no item held");

    a_done_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        s1_a_done_reg |-> need_a && need_b)
        else $error("second-wall flag set for an item with fewer than two walls");

    second_wall_follows: assert property (@(posedge clk) disable iff (!rst_n)
        walls.valid && walls.ready && !walls.run_last |=> walls.valid)
        else $error("second wall of a tile not presented right after the first");

    stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !tiles.ready |-> s1_valid_reg && (pend_a || need_b))
        else $error("input stalled with nothing pending");

endmodule

[verif/grid_wall_edge_extractor_checker.sv]
`timescale 1ns / 100ps
// Checker for grid_wall_edge_extractor: watches the register port and both channels,
// predicts the walls of each tile transfer and compares them in order.
// Depends on gwe_pkg and the channel interfaces in gwe_channels.sv.
module grid_wall_edge_extractor_checker #(
    parameter int MAX_TILES = gwe_pkg::MAX_TILES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gwe_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [gwe_pkg::CFG_DATA_W-1:0] cfg_data,
    gwe_tile_if                            tiles,
    gwe_wall_if                            walls,
    output int                             errors,
    output int                             walls_pending,
    output int                             walls_checked
);

    typedef struct packed {
        gwe_pkg::side_t                   side;
        logic [gwe_pkg::OUT_IDX_W-1:0]    col;
        logic [gwe_pkg::OUT_IDX_W-1:0]    row;
        logic signed [gwe_pkg::POS_W-1:0] x2;
        logic signed [gwe_pkg::POS_W-1:0] z2;
        logic                             last;
    } wall_rec_t;

    logic [gwe_pkg::SIZE_W-1:0]  tile_size;
    logic [gwe_pkg::COUNT_W-1:0] tiles_across;
    logic [gwe_pkg::COUNT_W-1:0] tiles_deep;
    logic                        row_flags [MAX_TILES];
    logic                        left_open;
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    wall_rec_t                   expected_walls [$];
    int                          err_cnt;
    int                          checked_cnt;

    function automatic int unsigned grid_dim(input logic [gwe_pkg::COUNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_TILES)
            return MAX_TILES;
        return 32'(v);
    endfunction

    // centre coordinates are kept doubled so the half-tile offset stays integral
    function automatic wall_rec_t make_wall(input gwe_pkg::side_t side, input int unsigned c,
                                            input int unsigned r);
        longint    s;
        longint    h2;
        longint    w;
        longint    d;
        longint    bx;
        longint    bz;
        longint    x2;
        longint    z2;
        wall_rec_t rec;
        s  = longint'(tile_size);
        h2 = 2 * longint'(tile_size / 2);
        w  = s * longint'(grid_dim(tiles_across));
        d  = s * longint'(grid_dim(tiles_deep));
        bx = 2 * s * longint'(c);
        bz = 2 * s * longint'(r);
        case (side)
            gwe_pkg::SIDE_LEFT:
            begin
                x2 = bx - w;
                z2 = bz + h2 - d;
            end
            gwe_pkg::SIDE_RIGHT:
            begin
                x2 = bx + 2 * s - w;
                z2 = bz + h2 - d;
            end
            gwe_pkg::SIDE_TOP:
            begin
                x2 = bx + h2 - w;
                z2 = bz - d;
            end
            default:
            begin
                x2 = bx + h2 - w;
                z2 = bz + 2 * s - d;
            end
        endcase
        rec.side = side;
        rec.col  = c[gwe_pkg::OUT_IDX_W-1:0];
        rec.row  = r[gwe_pkg::OUT_IDX_W-1:0];
        rec.x2   = x2[gwe_pkg::POS_W-1:0];
        rec.z2   = z2[gwe_pkg::POS_W-1:0];
        rec.last = 1'b0;
        return rec;
    endfunction

    function automatic void predict_walls(input logic open_now, input logic start);
        int unsigned across;
        int unsigned deep;
        int unsigned c;
        int unsigned r;
        logic        above;
        wall_rec_t   found [2];
        int          n;
        across = grid_dim(tiles_across);
        deep   = grid_dim(tiles_deep);
        n      = 0;
        if (start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        // left neighbour first, then the tile above
        if (c > 0)
        begin
            if (!open_now && left_open)
            begin
                found[n] = make_wall(gwe_pkg::SIDE_LEFT, c, r);
                n++;
            end
            else if (open_now && !left_open)
            begin
                found[n] = make_wall(gwe_pkg::SIDE_RIGHT, c - 1, r);
                n++;
            end
        end
        if (r > 0)
        begin
            above = row_flags[c];
            if (!open_now && above)
            begin
                found[n] = make_wall(gwe_pkg::SIDE_TOP, c, r);
                n++;
            end
            else if (open_now && !above)
            begin
                found[n] = make_wall(gwe_pkg::SIDE_BOTTOM, c, r - 1);
                n++;
            end
        end
        if (n > 0)
            found[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_walls.insert(expected_walls.size(), found[k]);
        row_flags[c] = open_now;
        left_open    = open_now;
        // a counter left past a shrunk grid wraps on the next advance
        if (c + 1 >= across)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= deep) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    function automatic void compare_field(input string name, input logic signed [63:0] want,
                                          input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic void check_wall();
        wall_rec_t want;
        if (expected_walls.size() == 0)
        begin
            $error("wall transfer with nothing expected: side %0d col %0d row %0d",
                   walls.wall_side, walls.wall_tile_col, walls.wall_tile_row);
            err_cnt++;
            return;
        end
        want = expected_walls.pop_front();
        checked_cnt++;
        compare_field("wall_side", want.side, walls.wall_side);
        compare_field("wall_tile_col", want.col, walls.wall_tile_col);
        compare_field("wall_tile_row", want.row, walls.wall_tile_row);
        compare_field("wall_pos_x2", want.x2, walls.wall_pos_x2);
        compare_field("wall_pos_z2", want.z2, walls.wall_pos_z2);
        compare_field("run_last", want.last, walls.run_last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_size    = gwe_pkg::SIZE_W'(1);
            tiles_across = gwe_pkg::COUNT_W'(1);
            tiles_deep   = gwe_pkg::COUNT_W'(1);
            left_open    = 1'b0;
            col_pos      = 0;
            row_pos      = 0;
            for (int k = 0; k < MAX_TILES; k++)
                row_flags[k] = 1'b0;
            expected_walls.delete();
            err_cnt       = 0;
            checked_cnt   = 0;
            errors        <= 0;
            walls_pending <= 0;
            walls_checked <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gwe_pkg::REG_TILE_SIZE:
                        tile_size    = cfg_data[gwe_pkg::SIZE_W-1:0];
                    gwe_pkg::REG_TILES_ACROSS:
                        tiles_across = cfg_data[gwe_pkg::COUNT_W-1:0];
                    gwe_pkg::REG_TILES_DEEP:
                        tiles_deep   = cfg_data[gwe_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (walls.valid && walls.ready)
                check_wall();
            if (tiles.valid && tiles.ready)
                predict_walls(tiles.tile_open, tiles.map_start);
            errors        <= err_cnt;
            walls_pending <= expected_walls.size();
            walls_checked <= checked_cnt;
        end
    end

endmodule

[verif/grid_wall_edge_extractor_tb.sv]
`timescale 1ns / 100ps
// Top of the grid_wall_edge_extractor bench: clock, reset, register writes, tile stimulus
// and the wall receiver. Needs gwe_pkg, gwe_channels.sv and the checker module.
module grid_wall_edge_extractor_tb;

    localparam int HOLD_CYCLES = 600;
    localparam logic [0:8] FIRST_GRID = 9'b010_101_000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [gwe_pkg::REG_IDX_W-1:0]  cfg_index;
    logic [gwe_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           tx_quiet;
    logic                           rx_quiet;
    logic                           hold_req;
    int                             errors;
    int                             walls_pending;
    int                             walls_checked;
    int                             tiles_sent;
    int                             settings_used;
    int unsigned                    grid_across;

    gwe_tile_if tiles ();
    gwe_wall_if walls ();

    grid_wall_edge_extractor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tiles     (tiles),
        .walls     (walls)
    );

    grid_wall_edge_extractor_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .tiles         (tiles),
        .walls         (walls),
        .errors        (errors),
        .walls_pending (walls_pending),
        .walls_checked (walls_checked)
    );

    always #10 clk = ~clk;

    function automatic int unsigned clamp_dim(input logic [gwe_pkg::COUNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > gwe_pkg::MAX_TILES_DEF)
            return gwe_pkg::MAX_TILES_DEF;
        return 32'(v);
    endfunction

    // drop valid, let every expected wall drain, then allow for in-flight tiles
    task automatic wait_idle();
        tiles.valid <= 1'b0;
        @(posedge clk);
        while (walls_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_grid(input logic [gwe_pkg::SIZE_W-1:0] size,
                            input logic [gwe_pkg::COUNT_W-1:0] across,
                            input logic [gwe_pkg::COUNT_W-1:0] deep);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= gwe_pkg::REG_TILE_SIZE;
        cfg_data  <= gwe_pkg::CFG_DATA_W'(size);
        @(posedge clk);
        cfg_index <= gwe_pkg::REG_TILES_ACROSS;
        cfg_data  <= across;
        @(posedge clk);
        cfg_index <= gwe_pkg::REG_TILES_DEEP;
        cfg_data  <= deep;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_tile(input logic open_flag, input logic start_flag);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            tiles.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tiles.valid     <= 1'b1;
        tiles.tile_open <= open_flag;
        tiles.map_start <= start_flag;
        @(posedge clk);
        while (tiles.ready !== 1'b1)
            @(posedge clk);
        tiles_sent++;
    endtask

    // wall receiver: random stalls, plus one long hold-off while tiles keep coming
    initial
    begin : wall_sink
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        walls.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else if (rx_quiet)
                stall = 0;
            else
                stall = $urandom_range(0, 19);
            if (stall > 0)
            begin
                walls.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            walls.ready <= 1'b1;
            @(posedge clk);
            while (walls.valid !== 1'b1)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int                          i;
        int                          phase;
        int                          n_items;
        int                          density;
        logic [gwe_pkg::SIZE_W-1:0]  size;
        logic [gwe_pkg::COUNT_W-1:0] across;
        logic [gwe_pkg::COUNT_W-1:0] deep;
        bit                          restart;
        bit                          start;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= gwe_pkg::REG_TILE_SIZE;
        cfg_data        <= '0;
        tiles.valid     <= 1'b0;
        tiles.tile_open <= 1'b0;
        tiles.map_start <= 1'b0;
        tx_quiet        <= 1'b0;
        rx_quiet        <= 1'b0;
        hold_req        <= 1'b0;
        tiles_sent    = 0;
        settings_used = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // 3x3 grid hitting all four sides and tiles with two walls
        set_grid(10'd7, 11'd3, 11'd3);
        for (i = 0; i < 9; i++)
            send_tile(FIRST_GRID[i], i == 0);
        // wrap past the last row, then a restart in the middle of a row
        send_tile(1'b1, 1'b0);
        send_tile(1'b0, 1'b0);
        send_tile(1'b1, 1'b1);
        send_tile(1'b0, 1'b0);
        // shrink the row while the column counter sits at the old last column
        set_grid(10'd7, 11'd2, 11'd3);
        send_tile(1'b1, 1'b0);
        send_tile(1'b0, 1'b0);
        send_tile(1'b1, 1'b0);
        send_tile(1'b1, 1'b0);
        // zero tile size, width below range, depth above range
        set_grid(10'd0, 11'd0, 11'd2047);
        send_tile(1'b0, 1'b1);
        send_tile(1'b1, 1'b0);
        send_tile(1'b0, 1'b0);
        send_tile(1'b1, 1'b0);
        send_tile(1'b1, 1'b0);
        grid_across = 1;

        for (phase = 0; phase < 9; phase++)
        begin
            if (phase == 4)
            begin
                // full-width grid: largest coordinates, long enough for the hold-off
                size    = 10'd1023;
                across  = 11'd2047;
                deep    = 11'd1024;
                n_items = 1040;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       size = 10'd1;
                    1:       size = 10'd1023;
                    2:       size = 10'd0;
                    default: size = gwe_pkg::SIZE_W'($urandom_range(1, 1023));
                endcase
                case ($urandom_range(0, 7))
                    0:       across = 11'd0;
                    1:       across = gwe_pkg::COUNT_W'($urandom_range(1025, 2047));
                    2:       across = 11'd1;
                    default: across = gwe_pkg::COUNT_W'($urandom_range(2, 12));
                endcase
                case ($urandom_range(0, 7))
                    0:       deep = 11'd0;
                    1:       deep = gwe_pkg::COUNT_W'($urandom_range(1025, 2047));
                    2:       deep = 11'd1;
                    default: deep = gwe_pkg::COUNT_W'($urandom_range(2, 10));
                endcase
                n_items = $urandom_range(40, 120);
            end
            // a grid may carry on only if no column beyond what its rows hold is needed
            restart     = (clamp_dim(across) > grid_across) || ($urandom_range(0, 2) != 0);
            grid_across = clamp_dim(across);
            density     = $urandom_range(15, 85);
            set_grid(size, across, deep);
            for (i = 0; i < n_items; i++)
            begin
                if (i % 48 == 0)
                begin
                    tx_quiet <= ($urandom_range(0, 3) == 0);
                    rx_quiet <= ($urandom_range(0, 3) == 0);
                end
                if (phase == 4 && i == 400)
                    hold_req <= 1'b1;
                start = (i == 0 && restart) || ($urandom_range(0, 59) == 0);
                send_tile($urandom_range(0, 99) < density, start);
            end
        end

        wait_idle();
        $display("Covered %0d tiles over %0d grid settings, %0d walls compared, %0d mismatches",
                 tiles_sent, settings_used, walls_checked, errors);
        if (walls_pending != 0)
            $error("%0d walls still expected at the end", walls_pending);
        if (errors == 0 && walls_pending == 0)
            $display("[grid_wall_edge_extractor] OK");
        else
            $display("[grid_wall_edge_extractor] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #12_000_000;
        $display("[grid_wall_edge_extractor] ERROR");
        $finish;
    end

endmodule
